// File: rtl/bsmd_pkg.sv
package bsmd_pkg;

  // background store and line store address widths
  localparam int PIX_AW  = 20;
  localparam int LINE_AW = 11;
  localparam int Q_AW    = 2;
  localparam int Q_DEPTH = 1 << Q_AW;
  localparam int TDATA_W = 80;

  localparam logic [12:0] MAX_DIM   = 13'd4096;
  localparam logic [8:0]  ALPHA_ONE = 9'd256;
  localparam logic [20:0] CNT_MAX   = 21'h1FFFFF;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH   = 3'd0,
    CFG_FRAME_HEIGHT  = 3'd1,
    CFG_DIFF_THRESH   = 3'd2,
    CFG_MIN_PIXELS    = 3'd3,
    CFG_DOWNSCALE     = 3'd4,
    CFG_BG_UPDATE     = 3'd5,
    CFG_ALPHA         = 3'd6,
    CFG_MAP_ENABLE    = 3'd7
  } cfg_idx_t;

  typedef struct packed {
    logic [12:0] img_width;
    logic [12:0] img_height;
    logic [7:0]  diff_threshold;
    logic [20:0] motion_min;
    logic        downscale_2x2;
    logic        background_update_enable;
    logic [8:0]  alpha;
    logic        motion_map_enable;
  } cfg_t;

  // one processed pixel and/or frame end, handed from front to back
  typedef struct packed {
    logic        proc;
    logic [7:0]  value;
    logic [24:0] base;
    logic [11:0] col;
    logic        was_ready;
    logic        end_frame;
  } q_item_t;

  typedef struct packed {
    logic        map_valid;
    logic        motion;
    logic [19:0] map_index;
    logic        is_last;
    logic        learned_frame;
    logic [20:0] motion_pixel_count;
    logic        global_motion;
    logic [31:0] frame_number;
  } out_t;

endpackage

// File: rtl/background_subtraction_motion_detect.sv
// channel   dir  handshake                  payload
// s_*       in   s_tvalid / s_tready        s_tdata: pixel
// m_*       out  m_tvalid / m_tready        m_tdata, m_tuser: map_valid, m_tlast: is_last
// cfg_*     in   cfg_valid / cfg_ready      cfg_index, cfg_data
//
// one pixel per cycle sustained while the output is not stalled; the background
// memory does one read and one write per cycle, with a write forwarded to a read
// of the same entry; a pixel's result passes the front register (loaded on the
// taking edge), then the queue, the back stage and the output register.
// rst clears positions, counters and handshake state; the background memory and
// line store are not cleared and need no pass after reset.
// a stalled output fills the output register, back stage, four-item queue and
// front register before s_tready drops.
module background_subtraction_motion_detect (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] pixel
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // [0] motion, [20:1] map_index, [21] learned_frame, [42:22] motion_pixel_count,
  // [43] global_motion, [75:44] frame_number, [79:76] zero
  output logic [bsmd_pkg::TDATA_W-1:0]  m_tdata,
  output logic [0:0]                    m_tuser,   // [0] map_valid
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [2:0]                    cfg_index,
  input  logic [20:0]                   cfg_data
);

  bsmd_pkg::cfg_t    cfg;
  logic              q_push_valid;
  logic              q_push_ready;
  bsmd_pkg::q_item_t q_push_item;
  logic              q_pop_valid;
  logic              q_pop_ready;
  bsmd_pkg::q_item_t q_pop_item;
  bsmd_pkg::out_t    res;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.img_width                <= 13'd1280;
      cfg.img_height               <= 13'd720;
      cfg.diff_threshold           <= 8'd25;
      cfg.motion_min               <= 21'd800;
      cfg.downscale_2x2            <= 1'b0;
      cfg.background_update_enable <= 1'b1;
      cfg.alpha                    <= 9'd248;
      cfg.motion_map_enable        <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (bsmd_pkg::cfg_idx_t'(cfg_index))
        bsmd_pkg::CFG_FRAME_WIDTH:  cfg.img_width                <= cfg_data[12:0];
        bsmd_pkg::CFG_FRAME_HEIGHT: cfg.img_height               <= cfg_data[12:0];
        bsmd_pkg::CFG_DIFF_THRESH:  cfg.diff_threshold           <= cfg_data[7:0];
        bsmd_pkg::CFG_MIN_PIXELS:   cfg.motion_min               <= cfg_data;
        bsmd_pkg::CFG_DOWNSCALE:    cfg.downscale_2x2            <= cfg_data[0];
        bsmd_pkg::CFG_BG_UPDATE:    cfg.background_update_enable <= cfg_data[0];
        bsmd_pkg::CFG_ALPHA:        cfg.alpha                    <= cfg_data[8:0];
        bsmd_pkg::CFG_MAP_ENABLE:   cfg.motion_map_enable        <= cfg_data[0];
        default: ;
      endcase
    end
  end

  bsmd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_pixel   (s_tdata),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item)
  );

  bsmd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (q_push_valid),
    .push_ready (q_push_ready),
    .push_item  (q_push_item),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item)
  );

  bsmd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .pop_valid  (q_pop_valid),
    .pop_ready  (q_pop_ready),
    .pop_item   (q_pop_item),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_item   (res)
  );

  assign m_tdata = {4'd0, res.frame_number, res.global_motion, res.motion_pixel_count,
                    res.learned_frame, res.map_index, res.motion};
  assign m_tuser = res.map_valid;
  assign m_tlast = res.is_last;

`ifndef SYNTHESIS
  // every item is a map item, a frame summary or both
  a_item_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tuser[0] || m_tlast))
    else $error("result carries neither map nor summary");

  // a learning frame reports nothing
  a_learned_quiet: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tlast && m_tdata[21]) |->
      (!m_tuser[0] && m_tdata[42:22] == 21'd0 && !m_tdata[43]))
    else $error("learned frame summary shows motion");

  // the front holds its item while the queue is full
  a_queue_push: assert property (@(posedge clk) disable iff (rst)
    (q_push_valid && !q_push_ready) |=> q_push_valid)
    else $error("front dropped an item on a full queue");
`endif

endmodule

// File: rtl/bsmd_front.sv
module bsmd_front (
  input  logic               clk,
  input  logic               rst,
  input  bsmd_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         in_pixel,
  output logic               push_valid,
  input  logic               push_ready,
  output bsmd_pkg::q_item_t  push_item
);

  typedef struct packed {
    logic        proc;
    logic        down;
    logic [8:0]  pix;
    logic [11:0] yy;
    logic [12:0] ww;
    logic [11:0] col;
    logic        was_ready;
    logic        end_frame;
  } f_reg_t;

  logic [11:0] x;
  logic [11:0] y;
  logic [8:0]  pending;
  logic        bg_ready;
  logic        f_valid;
  f_reg_t      f;
  f_reg_t      f_next;

  logic [9:0]  line_mem [0:(1 << bsmd_pkg::LINE_AW) - 1];
  logic [9:0]  line_rd;

  logic [12:0] w;
  logic [12:0] h;
  logic [11:0] hw;
  logic [11:0] hh;
  logic [10:0] c;
  logic        in_blk;
  logic        in_frm;
  logic [8:0]  pair;
  logic        end_line;
  logic        end_frame;
  logic        accept;
  logic        line_we;
  logic [10:0] avg_sum;
  logic [8:0]  avg;

  assign accept   = in_valid && in_ready;
  assign in_ready = !f_valid || push_ready;

  always_comb begin
    w = (cfg.img_width  > bsmd_pkg::MAX_DIM) ? bsmd_pkg::MAX_DIM : cfg.img_width;
    h = (cfg.img_height > bsmd_pkg::MAX_DIM) ? bsmd_pkg::MAX_DIM : cfg.img_height;
    hw = w[12:1];
    hh = h[12:1];
    c  = x[11:1];
    in_blk = ({1'b0, c} < hw) && ({1'b0, y[11:1]} < hh);
    in_frm = ({1'b0, x} < w) && ({1'b0, y} < h);
    pair = pending + {1'b0, in_pixel};
    end_line  = ({1'b0, x} + 13'd1) >= w;
    end_frame = end_line && (({1'b0, y} + 13'd1) >= h);
    line_we = cfg.downscale_2x2 && in_blk && x[0] && !y[0];

    f_next.down      = cfg.downscale_2x2;
    f_next.was_ready = bg_ready;
    f_next.end_frame = end_frame;
    if (cfg.downscale_2x2) begin
      f_next.proc = in_blk && x[0] && y[0];
      f_next.pix  = pair;
      f_next.yy   = {1'b0, y[11:1]};
      f_next.ww   = {1'b0, hw};
      f_next.col  = {1'b0, c};
    end else begin
      f_next.proc = in_frm;
      f_next.pix  = {1'b0, in_pixel};
      f_next.yy   = y;
      f_next.ww   = w;
      f_next.col  = x;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x        <= '0;
      y        <= '0;
      pending  <= '0;
      bg_ready <= 1'b0;
      f_valid  <= 1'b0;
    end else begin
      if (in_ready) begin
        f_valid <= accept && (f_next.proc || f_next.end_frame);
      end
      if (accept) begin
        if (cfg.downscale_2x2 && in_blk && !x[0]) begin
          pending <= {1'b0, in_pixel};
        end
        if (end_line) begin
          x <= '0;
          y <= end_frame ? 12'd0 : y + 12'd1;
        end else begin
          x <= x + 12'd1;
        end
        if (end_frame) begin
          bg_ready <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f       <= f_next;
      line_rd <= line_mem[c];
      if (line_we) begin
        line_mem[c] <= {1'b0, pair};
      end
    end
  end

  // 2x2 average: stored upper pair plus lower pair, over four
  always_comb begin
    avg_sum = {1'b0, line_rd} + {2'b0, f.pix};
    avg     = avg_sum[10:2];
  end

  assign push_valid          = f_valid;
  assign push_item.proc      = f.proc;
  assign push_item.value     = f.down ? (avg[8] ? 8'hFF : avg[7:0]) : f.pix[7:0];
  assign push_item.base      = {13'd0, f.yy} * {12'd0, f.ww};
  assign push_item.col       = f.col;
  assign push_item.was_ready = f.was_ready;
  assign push_item.end_frame = f.end_frame;

endmodule

// File: rtl/bsmd_queue.sv
module bsmd_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  bsmd_pkg::q_item_t  push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output bsmd_pkg::q_item_t  pop_item
);

  bsmd_pkg::q_item_t          slots [0:bsmd_pkg::Q_DEPTH - 1];
  logic [bsmd_pkg::Q_AW-1:0]  wr_ptr;
  logic [bsmd_pkg::Q_AW-1:0]  rd_ptr;
  logic [bsmd_pkg::Q_AW:0]    count;
  logic                       push;
  logic                       pop;

  assign push_ready = count != (bsmd_pkg::Q_AW + 1)'(bsmd_pkg::Q_DEPTH);
  assign pop_valid  = count != '0;
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

// File: rtl/bsmd_back.sv
module bsmd_back (
  input  logic               clk,
  input  logic               rst,
  input  bsmd_pkg::cfg_t     cfg,
  input  logic               pop_valid,
  output logic               pop_ready,
  input  bsmd_pkg::q_item_t  pop_item,
  output logic               out_valid,
  input  logic               out_ready,
  output bsmd_pkg::out_t     out_item
);

  logic [7:0]  bg_mem [0:(1 << bsmd_pkg::PIX_AW) - 1];
  logic [7:0]  bg_rd;
  logic        fwd;
  logic [7:0]  fwd_data;

  logic        b_valid;
  logic        b_proc;
  logic [7:0]  b_value;
  logic [bsmd_pkg::PIX_AW-1:0] b_idx;
  logic        b_was_ready;
  logic        b_end;

  logic [20:0] motion_cnt;
  logic [31:0] frame_cnt;

  logic [24:0] sum;
  logic        pop;
  logic        b_fire;
  logic        b_emit;
  logic        b_we;
  logic [7:0]  b_wdata;
  logic        out_free;
  logic [7:0]  bg;
  logic [7:0]  diff;
  logic        mot;
  logic [8:0]  a;
  logic [8:0]  inv;
  logic [16:0] pb;
  logic [16:0] pv;
  logic [16:0] blend;
  logic [20:0] cnt_now;
  logic        map_on;
  bsmd_pkg::out_t o_next;

  assign sum       = pop_item.base + {13'd0, pop_item.col};
  assign pop_ready = !b_valid || b_fire;
  assign pop       = pop_valid && pop_ready;
  assign out_free  = !out_valid || out_ready;

  always_comb begin
    // last write to the same entry has not landed in the read data yet
    bg   = fwd ? fwd_data : bg_rd;
    diff = (b_value > bg) ? b_value - bg : bg - b_value;
    mot  = b_proc && b_was_ready && (diff > cfg.diff_threshold);
    a    = (cfg.alpha > bsmd_pkg::ALPHA_ONE) ? bsmd_pkg::ALPHA_ONE : cfg.alpha;
    inv  = bsmd_pkg::ALPHA_ONE - a;
    pb   = {9'd0, bg} * {8'd0, a};
    pv   = {9'd0, b_value} * {8'd0, inv};
    blend = pb + pv;
    b_we    = b_proc && (!b_was_ready || cfg.background_update_enable);
    b_wdata = b_was_ready ? blend[15:8] : b_value;
    cnt_now = (mot && motion_cnt != bsmd_pkg::CNT_MAX) ? motion_cnt + 21'd1 : motion_cnt;
    map_on  = b_proc && b_was_ready && cfg.motion_map_enable;
    b_emit  = map_on || b_end;
    b_fire  = b_valid && (!b_emit || out_free);

    o_next.map_valid          = map_on;
    o_next.motion             = map_on && mot;
    o_next.map_index          = map_on ? b_idx : '0;
    o_next.is_last            = b_end;
    o_next.learned_frame      = b_end && !b_was_ready;
    o_next.motion_pixel_count = (b_end && b_was_ready) ? cnt_now : '0;
    o_next.global_motion      = b_end && b_was_ready && (cnt_now >= cfg.motion_min);
    o_next.frame_number       = b_end ? frame_cnt + 32'd1 : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid    <= 1'b0;
      out_valid  <= 1'b0;
      motion_cnt <= '0;
      frame_cnt  <= '0;
    end else begin
      if (pop_ready) begin
        b_valid <= pop_valid;
      end
      if (b_fire && b_emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (b_fire) begin
        if (b_end) begin
          motion_cnt <= '0;
          frame_cnt  <= frame_cnt + 32'd1;
        end else begin
          motion_cnt <= cnt_now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_proc      <= pop_item.proc && (sum[24:bsmd_pkg::PIX_AW] == '0);
      b_value     <= pop_item.value;
      b_idx       <= sum[bsmd_pkg::PIX_AW-1:0];
      b_was_ready <= pop_item.was_ready;
      b_end       <= pop_item.end_frame;
      bg_rd       <= bg_mem[sum[bsmd_pkg::PIX_AW-1:0]];
      fwd         <= b_fire && b_we && (b_idx == sum[bsmd_pkg::PIX_AW-1:0]);
      fwd_data    <= b_wdata;
    end
    if (b_fire && b_we) begin
      bg_mem[b_idx] <= b_wdata;
    end
    if (b_fire && b_emit) begin
      out_item <= o_next;
    end
  end

endmodule

// File: bench/background_subtraction_motion_detect_test.sv
module background_subtraction_motion_detect_test;

  typedef enum {PIX_NOISE, PIX_EXTREME, PIX_SCENE, PIX_OBJECT} pix_style_t;
  typedef enum {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

  // mirrors the detector: background memory, line store, positions, counters
  class bg_motion_track;
    logic [12:0] img_width;
    logic [12:0] img_height;
    logic [7:0]  diff_threshold;
    logic [20:0] motion_min;
    logic        downscale;
    logic        bg_update;
    logic [8:0]  alpha;
    logic        map_enable;

    logic [7:0]  bg_store [int unsigned];
    logic [9:0]  pair_sums [0:(1 << bsmd_pkg::LINE_AW)];
    logic [8:0]  pending_sum;
    int unsigned col;
    int unsigned row;
    logic [20:0] motion_count;
    logic [31:0] frames_done;
    bit          bg_ready;

    bsmd_pkg::out_t pending_results[$];
    int unsigned mismatches;
    int unsigned results_seen;

    function new();
      img_width = 13'd1280;
      img_height = 13'd720;
      diff_threshold = 8'd25;
      motion_min = 21'd800;
      downscale = 1'b0;
      bg_update = 1'b1;
      alpha = 9'd248;
      map_enable = 1'b0;
      foreach (pair_sums[i]) pair_sums[i] = '0;
      pending_sum = '0;
      col = 0;
      row = 0;
      motion_count = '0;
      frames_done = '0;
      bg_ready = 1'b0;
      mismatches = 0;
      results_seen = 0;
    endfunction

    function void set_register(bsmd_pkg::cfg_idx_t idx, logic [20:0] data);
      case (idx)
        bsmd_pkg::CFG_FRAME_WIDTH:  img_width = data[12:0];
        bsmd_pkg::CFG_FRAME_HEIGHT: img_height = data[12:0];
        bsmd_pkg::CFG_DIFF_THRESH:  diff_threshold = data[7:0];
        bsmd_pkg::CFG_MIN_PIXELS:   motion_min = data;
        bsmd_pkg::CFG_DOWNSCALE:    downscale = data[0];
        bsmd_pkg::CFG_BG_UPDATE:    bg_update = data[0];
        bsmd_pkg::CFG_ALPHA:        alpha = data[8:0];
        bsmd_pkg::CFG_MAP_ENABLE:   map_enable = data[0];
        default: ;
      endcase
    endfunction

    function void take_pixel(logic [7:0] pix);
      int unsigned w, h, hw, c, idx, value, pair, b, d, a, blend;
      bit processed, mot, emit_map, was_ready, end_line, end_frame;
      bsmd_pkg::out_t r;
      w = (img_width < bsmd_pkg::MAX_DIM) ? img_width : bsmd_pkg::MAX_DIM;
      h = (img_height < bsmd_pkg::MAX_DIM) ? img_height : bsmd_pkg::MAX_DIM;
      processed = 1'b0;
      mot = 1'b0;
      emit_map = 1'b0;
      value = 0;
      idx = 0;
      was_ready = bg_ready;

      if (downscale) begin
        hw = w >> 1;
        c = col >> 1;
        if (c < hw && (row >> 1) < (h >> 1) && c < (1 << bsmd_pkg::LINE_AW)) begin
          if ((col & 1) == 0) begin
            pending_sum = pix;
          end else begin
            pair = pending_sum + pix;
            if ((row & 1) == 0) begin
              pair_sums[c] = pair[9:0];
            end else begin
              value = (pair_sums[c] + pair) >> 2;
              if (value > 255) value = 255;
              idx = (row >> 1) * hw + c;
              processed = 1'b1;
            end
          end
        end
      end else if (col < w && row < h) begin
        value = pix;
        idx = row * w + col;
        processed = 1'b1;
      end
      // pixels beyond the background memory are dropped
      if (processed && idx >= (1 << bsmd_pkg::PIX_AW)) processed = 1'b0;

      if (processed) begin
        if (!was_ready) begin
          bg_store[idx] = value[7:0];
        end else begin
          b = bg_store.exists(idx) ? bg_store[idx] : 0;
          d = (value > b) ? value - b : b - value;
          mot = d > diff_threshold;
          if (mot && motion_count != bsmd_pkg::CNT_MAX) motion_count++;
          if (bg_update) begin
            a = (alpha > bsmd_pkg::ALPHA_ONE) ? bsmd_pkg::ALPHA_ONE : alpha;
            blend = (b * a + value * (bsmd_pkg::ALPHA_ONE - a)) >> 8;
            bg_store[idx] = blend[7:0];
          end
          emit_map = map_enable;
        end
      end

      end_line = (col + 1 >= w);
      end_frame = end_line && (row + 1 >= h);
      if (end_line) begin
        col = 0;
        row = end_frame ? 0 : ((row + 1) & 12'hFFF);
      end else begin
        col = (col + 1) & 12'hFFF;
      end

      if (emit_map || end_frame) begin
        r = '0;
        if (emit_map) begin
          r.map_valid = 1'b1;
          r.motion = mot;
          r.map_index = idx[19:0];
        end
        if (end_frame) begin
          frames_done++;
          r.is_last = 1'b1;
          r.learned_frame = !was_ready;
          r.motion_pixel_count = was_ready ? motion_count : '0;
          r.global_motion = was_ready && (motion_count >= motion_min);
          r.frame_number = frames_done;
          bg_ready = 1'b1;
          motion_count = '0;
        end
        pending_results = {pending_results, r};
      end
    endfunction

    function string show(bsmd_pkg::out_t v);
      return $sformatf({"map_valid=%0d motion=%0d index=%0d last=%0d learned=%0d",
                        " count=%0d gm=%0d fn=%0d"},
                       v.map_valid, v.motion, v.map_index, v.is_last, v.learned_frame,
                       v.motion_pixel_count, v.global_motion, v.frame_number);
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%s", msg);
    endfunction

    function void check_result(bsmd_pkg::out_t got);
      bsmd_pkg::out_t want;
      string diffs;
      results_seen++;
      if (pending_results.size() == 0) begin
        report($sformatf("item %0d with nothing expected: %s", results_seen, show(got)));
        return;
      end
      want = pending_results.pop_front();
      diffs = "";
      if (got.map_valid !== want.map_valid) diffs = {diffs, " map_valid"};
      if (got.motion !== want.motion) diffs = {diffs, " motion"};
      if (got.map_index !== want.map_index) diffs = {diffs, " map_index"};
      if (got.is_last !== want.is_last) diffs = {diffs, " is_last"};
      if (got.learned_frame !== want.learned_frame) diffs = {diffs, " learned_frame"};
      if (got.motion_pixel_count !== want.motion_pixel_count) diffs = {diffs, " count"};
      if (got.global_motion !== want.global_motion) diffs = {diffs, " global_motion"};
      if (got.frame_number !== want.frame_number) diffs = {diffs, " frame_number"};
      if (diffs != "")
        report($sformatf("item %0d differs in%s\n  expected %s\n  actual   %s",
                         results_seen, diffs, show(want), show(got)));
    endfunction
  endclass

  logic                           clk;
  logic                           rst;
  logic                           s_tvalid;
  logic                           s_tready;
  logic [7:0]                     s_tdata;
  logic                           m_tvalid;
  logic                           m_tready;
  logic [bsmd_pkg::TDATA_W-1:0]   m_tdata;
  logic [0:0]                     m_tuser;
  logic                           m_tlast;
  logic                           cfg_valid;
  logic                           cfg_ready;
  logic [2:0]                     cfg_index;
  logic [20:0]                    cfg_data;

  bg_motion_track track = new();
  bsmd_pkg::out_t seen;
  bit          hold_req;
  int unsigned burst_left;
  int unsigned pixels_sent;

  background_subtraction_motion_detect dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready)
        track.set_register(bsmd_pkg::cfg_idx_t'(cfg_index), cfg_data);
      if (s_tvalid && s_tready) track.take_pixel(s_tdata);
      if (m_tvalid && m_tready) begin
        seen.map_valid = m_tuser[0];
        seen.motion = m_tdata[0];
        seen.map_index = m_tdata[20:1];
        seen.is_last = m_tlast;
        seen.learned_frame = m_tdata[21];
        seen.motion_pixel_count = m_tdata[42:22];
        seen.global_motion = m_tdata[43];
        seen.frame_number = m_tdata[75:44];
        track.check_result(seen);
      end
    end
  end

  // output side: changing stall patterns plus one long hold on request
  initial begin : rx_side
    rx_mode_t mode;
    int unsigned span, tick;
    bit held;
    m_tready = 1'b0;
    mode = RX_OPEN;
    span = 0;
    tick = 0;
    held = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req && !held) begin
        held = 1'b1;
        m_tready = 1'b0;
        repeat (300) @(negedge clk);
      end
      if (span == 0) begin
        mode = rx_mode_t'($urandom_range(0, 3));
        span = $urandom_range(20, 150);
      end
      span--;
      tick++;
      case (mode)
        RX_OPEN:   m_tready = 1'b1;
        RX_COIN:   m_tready = ($urandom_range(0, 1) == 1);
        RX_SPARSE: m_tready = ($urandom_range(0, 3) == 0);
        default:   m_tready = (tick % 5) < 3;
      endcase
    end
  end

  task automatic write_reg(input bsmd_pkg::cfg_idx_t idx, input int unsigned value);
    cfg_index = idx;
    cfg_data = 21'(value);
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_mode(input int unsigned w, input int unsigned h, input int unsigned thr,
                          input int unsigned minp, input int unsigned ds,
                          input int unsigned upd, input int unsigned alf,
                          input int unsigned map);
    write_reg(bsmd_pkg::CFG_FRAME_WIDTH, w);
    write_reg(bsmd_pkg::CFG_FRAME_HEIGHT, h);
    write_reg(bsmd_pkg::CFG_DIFF_THRESH, thr);
    write_reg(bsmd_pkg::CFG_MIN_PIXELS, minp);
    write_reg(bsmd_pkg::CFG_DOWNSCALE, ds);
    write_reg(bsmd_pkg::CFG_BG_UPDATE, upd);
    write_reg(bsmd_pkg::CFG_ALPHA, alf);
    write_reg(bsmd_pkg::CFG_MAP_ENABLE, map);
  endtask

  // bursts of random length, sometimes long, mostly with idle gaps between them
  task automatic send_pixel(input logic [7:0] pix);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        s_tvalid = 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    s_tdata = pix;
    s_tvalid = 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    burst_left--;
    pixels_sent++;
  endtask

  function automatic logic [7:0] scene_pixel(input pix_style_t style);
    int unsigned v;
    v = track.col * 9 + track.row * 17 + 60;
    case (style)
      PIX_NOISE:   v = $urandom_range(0, 255);
      PIX_EXTREME: v = $urandom_range(0, 1) ? 255 : 0;
      PIX_SCENE:   v = v + $urandom_range(0, 40) - 20;
      default: begin
        // a block pattern that shifts every frame
        if (((track.col / 3 + track.row / 3 + track.frames_done) % 4) == 0) v = v + 128;
        v = v + $urandom_range(0, 8);
      end
    endcase
    return v[7:0];
  endfunction

  // send until the frame in progress closes
  task automatic run_frame(input pix_style_t style);
    do send_pixel(scene_pixel(style));
    while (track.col != 0 || track.row != 0);
  endtask

  task automatic settle();
    s_tvalid = 1'b0;
    while (track.pending_results.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  initial begin : stimulus
    int unsigned w, h, base_count;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    hold_req = 1'b0;
    burst_left = 0;
    pixels_sent = 0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // learned frame covers every background index that later frames touch
    set_mode(12, 10, 25, 800, 0, 1, 248, 1);
    run_frame(PIX_NOISE);
    settle();

    set_mode(2, 2, 0, 0, 0, 1, 0, 1);
    run_frame(PIX_EXTREME);
    run_frame(PIX_EXTREME);
    settle();
    set_mode(2, 2, 255, 1048576, 0, 1, 256, 1);
    run_frame(PIX_EXTREME);
    settle();

    // downscaled with alpha above full weight
    set_mode(4, 4, 40, 2, 1, 1, 511, 1);
    run_frame(PIX_NOISE);
    settle();

    // degenerate sizes: nothing processed, single pixel, odd edges dropped
    set_mode(1, 2, 20, 0, 1, 1, 128, 1);
    run_frame(PIX_NOISE);
    settle();
    set_mode(0, 0, 20, 0, 0, 1, 128, 1);
    run_frame(PIX_NOISE);
    settle();
    set_mode(3, 3, 20, 1, 1, 0, 128, 1);
    run_frame(PIX_NOISE);
    settle();

    // width and then height shrink while a frame is open
    set_mode(8, 6, 15, 3, 0, 1, 64, 1);
    repeat (20) send_pixel(scene_pixel(PIX_SCENE));
    settle();
    write_reg(bsmd_pkg::CFG_FRAME_WIDTH, 2);
    run_frame(PIX_SCENE);
    settle();
    write_reg(bsmd_pkg::CFG_FRAME_WIDTH, 8);
    repeat (30) send_pixel(scene_pixel(PIX_OBJECT));
    settle();
    write_reg(bsmd_pkg::CFG_FRAME_HEIGHT, 2);
    run_frame(PIX_OBJECT);
    settle();

    // oversized sizes, cut short partway through the frame
    set_mode(8191, 2, 30, 100, 1, 1, 200, 1);
    repeat (12) send_pixel(scene_pixel(PIX_SCENE));
    settle();
    write_reg(bsmd_pkg::CFG_FRAME_WIDTH, 12);
    run_frame(PIX_SCENE);
    settle();
    set_mode(2, 8191, 30, 1000, 0, 0, 0, 0);
    repeat (10) send_pixel(scene_pixel(PIX_OBJECT));
    settle();
    write_reg(bsmd_pkg::CFG_FRAME_HEIGHT, 6);
    run_frame(PIX_OBJECT);
    settle();

    // long output stall while pixels keep coming
    set_mode(10, 6, 10, 20, 0, 1, 192, 1);
    hold_req = 1'b1;
    run_frame(PIX_OBJECT);
    settle();

    base_count = pixels_sent;
    while (pixels_sent - base_count < 200) begin
      if ($urandom_range(0, 2) != 0) begin
        settle();
        w = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 12);
        h = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 10);
        set_mode(w, h,
                 ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40),
                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 21'h1FFFFF)
                                             : $urandom_range(0, w * h / 2 + 1),
                 $urandom_range(0, 1), $urandom_range(0, 3) != 0,
                 ($urandom_range(0, 5) == 0) ? $urandom_range(257, 511) : $urandom_range(0, 256),
                 $urandom_range(0, 3) != 0);
      end
      run_frame(pix_style_t'($urandom_range(0, 3)));
    end
    settle();

    if (track.mismatches == 0 && track.pending_results.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// File: background_subtraction_motion_detect.f
rtl/bsmd_pkg.sv
rtl/bsmd_front.sv
rtl/bsmd_queue.sv
rtl/bsmd_back.sv
rtl/background_subtraction_motion_detect.sv
bench/background_subtraction_motion_detect_test.sv
